// File: rtl/core/lsah_pkg.sv
// Shared types, constants and register codes for the axis homing block.
package lsah_pkg;

  localparam int unsigned SPEED_W = 15;
  localparam int unsigned TOL_W   = 8;
  localparam int unsigned POS_W   = 16;
  localparam int unsigned CFG_W   = 15;

  localparam logic [SPEED_W-1:0] DRIVE_SPEED_RST = 15'd500;
  localparam logic [TOL_W-1:0]   HOME_TOL_RST    = 8'd5;

  typedef enum logic [0:0] {
    CFG_DRIVE_SPEED = 1'b0,
    CFG_HOME_TOL    = 1'b1
  } cfg_reg_t;

  localparam logic OP_LIMIT    = 1'b0;
  localparam logic OP_POSITION = 1'b1;
  localparam logic SIDE_FWD    = 1'b0;
  localparam logic SIDE_REAR   = 1'b1;

  typedef struct packed {
    logic                    awaiting_first;
    logic                    forward_seen;
    logic                    rear_seen;
    logic signed [POS_W-1:0] last_position;
    logic signed [POS_W-1:0] max_position;
    logic signed [POS_W-1:0] min_position;
    logic signed [POS_W-1:0] mid_position;
    logic signed [POS_W-1:0] current_speed;
    logic                    finished;
  } axis_state_t;

  typedef struct packed {
    logic signed [POS_W-1:0] speed_cmd;
    logic                    mode_pulse;
    logic                    calibrated;
    logic signed [POS_W-1:0] setpoint;
    logic signed [POS_W-1:0] range_min;
    logic signed [POS_W-1:0] range_max;
    logic                    homing_done;
  } axis_result_t;

  typedef struct packed {
    logic [SPEED_W-1:0] drive_speed;
    logic [TOL_W-1:0]   home_tolerance;
  } axis_cfg_t;

endpackage

// File: rtl/core/lsah_in_if.sv
// Input channel: limit events and position reports.
interface lsah_in_if;
  logic                                      valid;
  logic                                      ready;
  logic                                      op;
  logic                                      limit_side;
  logic signed [lsah_pkg::POS_W-1:0]         position;

  modport source (output valid, output op, output limit_side, output position, input ready);
  modport sink   (input valid, input op, input limit_side, input position, output ready);
endinterface

// File: rtl/core/lsah_out_if.sv
// Result channel: speed command, calibration and homing status.
interface lsah_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [lsah_pkg::POS_W-1:0] speed_cmd;
  logic                              mode_pulse;
  logic                              calibrated;
  logic signed [lsah_pkg::POS_W-1:0] setpoint;
  logic signed [lsah_pkg::POS_W-1:0] range_min;
  logic signed [lsah_pkg::POS_W-1:0] range_max;
  logic                              homing_done;

  modport source (output valid, output speed_cmd, output mode_pulse, output calibrated,
                  output setpoint, output range_min, output range_max,
                  output homing_done, input ready);
  modport sink   (input valid, input speed_cmd, input mode_pulse, input calibrated,
                  input setpoint, input range_min, input range_max,
                  input homing_done, output ready);
endinterface

// File: rtl/core/lsah_cfg_if.sv
// Configuration write channel: register index and write data.
interface lsah_cfg_if;
  logic                         valid;
  logic                         ready;
  lsah_pkg::cfg_reg_t           index;
  logic [lsah_pkg::CFG_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/core/lsah_step.sv
// Next-state and result logic for one homing transaction.
module lsah_step (
  input  lsah_pkg::axis_state_t              st,
  input  lsah_pkg::axis_cfg_t                cfg,
  input  logic                               op,
  input  logic                               limit_side,
  input  logic signed [lsah_pkg::POS_W-1:0]  position,
  output lsah_pkg::axis_state_t              st_nxt,
  output lsah_pkg::axis_result_t             res
);

  logic signed [lsah_pkg::POS_W-1:0] spd_pos;
  logic signed [lsah_pkg::POS_W-1:0] spd_neg;

  assign spd_pos = {1'b0, cfg.drive_speed};
  assign spd_neg = -spd_pos;

  always_comb begin
    logic [lsah_pkg::POS_W:0]   sum;
    logic [lsah_pkg::POS_W:0]   sum_adj;
    logic [lsah_pkg::POS_W:0]   diff;
    logic [lsah_pkg::POS_W:0]   offset;
    logic [lsah_pkg::POS_W:0]   offset_abs;
    logic                       mode;
    logic                       cal;
    logic                       done;
    st_nxt     = st;
    mode       = 1'b0;
    cal        = 1'b0;
    done       = 1'b0;
    sum        = '0;
    sum_adj    = '0;
    diff       = '0;
    offset     = '0;
    offset_abs = '0;
    if (!st.finished) begin
      if (op == lsah_pkg::OP_LIMIT) begin
        if (st.awaiting_first) begin
          st_nxt.current_speed  = (limit_side == lsah_pkg::SIDE_FWD) ? spd_pos : spd_neg;
          st_nxt.awaiting_first = 1'b0;
          mode                  = 1'b1;
        end else if (limit_side == lsah_pkg::SIDE_FWD && !st.forward_seen) begin
          st_nxt.forward_seen  = 1'b1;
          st_nxt.current_speed = spd_neg;
          st_nxt.max_position  = st.last_position;
          mode                 = 1'b1;
        end else if (limit_side == lsah_pkg::SIDE_REAR && !st.rear_seen) begin
          st_nxt.rear_seen     = 1'b1;
          st_nxt.current_speed = spd_pos;
          st_nxt.min_position  = st.last_position;
          mode                 = 1'b1;
        end
        if (st_nxt.forward_seen && st_nxt.rear_seen) begin
          // halve with truncation toward zero: bias negative sums by one
          sum     = {st_nxt.max_position[lsah_pkg::POS_W-1], st_nxt.max_position}
                  + {st_nxt.min_position[lsah_pkg::POS_W-1], st_nxt.min_position};
          sum_adj = sum + {{lsah_pkg::POS_W{1'b0}}, sum[lsah_pkg::POS_W]};
          st_nxt.mid_position = sum_adj[lsah_pkg::POS_W:1];
          diff    = {st_nxt.mid_position[lsah_pkg::POS_W-1], st_nxt.mid_position}
                  - {st.last_position[lsah_pkg::POS_W-1], st.last_position};
          st_nxt.current_speed = diff[lsah_pkg::POS_W] ? spd_neg : spd_pos;
          cal = 1'b1;
        end
      end else begin
        st_nxt.last_position = position;
        if (st.forward_seen && st.rear_seen) begin
          offset     = {position[lsah_pkg::POS_W-1], position}
                     - {st.mid_position[lsah_pkg::POS_W-1], st.mid_position};
          offset_abs = offset[lsah_pkg::POS_W] ? -offset : offset;
          if (offset_abs < {{(lsah_pkg::POS_W+1-lsah_pkg::TOL_W){1'b0}}, cfg.home_tolerance})
          begin
            mode                 = 1'b1;
            done                 = 1'b1;
            st_nxt.current_speed = '0;
            st_nxt.finished      = 1'b1;
          end
        end
      end
    end
    res.speed_cmd   = st_nxt.current_speed;
    res.mode_pulse  = mode;
    res.calibrated  = cal;
    res.setpoint    = cal ? st_nxt.mid_position : '0;
    res.range_min   = cal ? st_nxt.min_position : '0;
    res.range_max   = cal ? st_nxt.max_position : '0;
    res.homing_done = done;
  end

endmodule

// File: rtl/core/limit_switch_axis_homing_top.sv
// Top level: limit-switch calibration and homing of a linear axis.
// Latency: a result is valid the cycle after its input transaction is accepted.
// Throughput: one transaction per cycle unless the output stalls; the output register frees as it drains.
// Input ready drops only while the output register holds a result not yet taken.
// Reset (synchronous, rst_n low): state to awaiting first switch, speed 0,
// drive_speed 500, home_tolerance 5, output empty.
module limit_switch_axis_homing_top (
  input  logic              clk,
  input  logic              rst_n,
  lsah_in_if.sink           in_if,
  lsah_out_if.source        out_if,
  lsah_cfg_if.sink          cfg_if
);

  lsah_pkg::axis_state_t  st_r;
  lsah_pkg::axis_state_t  st_nxt;
  lsah_pkg::axis_cfg_t    cfg_r;
  lsah_pkg::axis_result_t res;
  lsah_pkg::axis_result_t res_r;
  logic                   out_valid_r;
  logic                   in_fire;

  assign in_if.ready  = !out_valid_r || out_if.ready;
  assign in_fire      = in_if.valid && in_if.ready;
  assign cfg_if.ready = 1'b1;

  lsah_step u_step (
    .st         (st_r),
    .cfg        (cfg_r),
    .op         (in_if.op),
    .limit_side (in_if.limit_side),
    .position   (in_if.position),
    .st_nxt     (st_nxt),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.drive_speed    <= lsah_pkg::DRIVE_SPEED_RST;
      cfg_r.home_tolerance <= lsah_pkg::HOME_TOL_RST;
    end else if (cfg_if.valid) begin
      unique case (cfg_if.index)
        lsah_pkg::CFG_DRIVE_SPEED: cfg_r.drive_speed    <= cfg_if.data[lsah_pkg::SPEED_W-1:0];
        lsah_pkg::CFG_HOME_TOL:    cfg_r.home_tolerance <= cfg_if.data[lsah_pkg::TOL_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.awaiting_first <= 1'b1;
      st_r.forward_seen   <= 1'b0;
      st_r.rear_seen      <= 1'b0;
      st_r.last_position  <= '0;
      st_r.max_position   <= '0;
      st_r.min_position   <= '0;
      st_r.mid_position   <= '0;
      st_r.current_speed  <= '0;
      st_r.finished       <= 1'b0;
      out_valid_r         <= 1'b0;
    end else begin
      if (in_fire) begin
        st_r        <= st_nxt;
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload register: load on accept, hold otherwise
  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_r <= res;
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.speed_cmd   = res_r.speed_cmd;
  assign out_if.mode_pulse  = res_r.mode_pulse;
  assign out_if.calibrated  = res_r.calibrated;
  assign out_if.setpoint    = res_r.setpoint;
  assign out_if.range_min   = res_r.range_min;
  assign out_if.range_max   = res_r.range_max;
  assign out_if.homing_done = res_r.homing_done;

endmodule

// File: rtl/core/lsah_checker.sv
// Port-level checks for the axis homing top level, bound to it.
module lsah_checker (
  input  logic        clk,
  input  logic        rst_n,
  lsah_in_if.sink     in_if,
  lsah_out_if.source  out_if
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && !out_if.ready |=> out_if.valid)
    else $error("result dropped while stalled");

  // every accepted transaction yields a result in the next cycle
  a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_if.valid && in_if.ready |=> out_if.valid)
    else $error("accepted transaction produced no result");

  // an empty output register never blocks input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_if.valid |-> in_if.ready)
    else $error("input stalled with empty output");

  // homing completion stops the drive and issues a mode command
  a_done_stops: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && out_if.homing_done |->
      out_if.speed_cmd == '0 && out_if.mode_pulse && !out_if.calibrated)
    else $error("homing done with drive still active");

  // setpoint and range read zero when not issued
  a_cal_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && !out_if.calibrated |->
      out_if.setpoint == '0 && out_if.range_min == '0 && out_if.range_max == '0)
    else $error("range fields nonzero without calibration");

endmodule

bind limit_switch_axis_homing_top lsah_checker u_lsah_checker (
  .clk    (clk),
  .rst_n  (rst_n),
  .in_if  (in_if),
  .out_if (out_if)
);

// File: tb/tb_limit_switch_axis_homing_top.sv
// Self-checking testbench for the limit-switch calibration and homing block.
module tb_limit_switch_axis_homing_top;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_ITEMS    = 300;
  localparam int HOMING_ITEMS   = 400;
  localparam int IGNORED_ITEMS  = 25;

  typedef logic signed [lsah_pkg::POS_W-1:0] pos_t;
  typedef logic [lsah_pkg::SPEED_W-1:0]      speed_t;
  typedef logic [lsah_pkg::TOL_W-1:0]        tol_t;
  typedef logic [lsah_pkg::CFG_W-1:0]        cfg_word_t;

  class axis_homing_scoreboard;
    speed_t                  speed_mag;
    tol_t                    tol;
    bit                      first_pending;
    bit                      fwd_seen;
    bit                      rear_seen;
    bit                      homed;
    pos_t                    last_pos;
    pos_t                    max_pos;
    pos_t                    min_pos;
    pos_t                    mid_pos;
    pos_t                    speed;
    lsah_pkg::axis_result_t  pending[$];
    int                      errors;

    function new();
      speed_mag     = lsah_pkg::DRIVE_SPEED_RST;
      tol           = lsah_pkg::HOME_TOL_RST;
      first_pending = 1'b1;
      fwd_seen      = 1'b0;
      rear_seen     = 1'b0;
      homed         = 1'b0;
      last_pos      = '0;
      max_pos       = '0;
      min_pos       = '0;
      mid_pos       = '0;
      speed         = '0;
      errors        = 0;
    endfunction

    function void set_reg(lsah_pkg::cfg_reg_t idx, cfg_word_t data);
      if (idx == lsah_pkg::CFG_DRIVE_SPEED) begin
        speed_mag = data[lsah_pkg::SPEED_W-1:0];
      end else begin
        tol = data[lsah_pkg::TOL_W-1:0];
      end
    endfunction

    function bit calibrated();
      return fwd_seen && rear_seen;
    endfunction

    // True when a position report at pos would end homing.
    function bit homes(pos_t pos);
      int offset;
      offset = int'(pos) - int'(mid_pos);
      if (offset < 0) offset = -offset;
      return calibrated() && !homed && (offset < int'(tol));
    endfunction

    function void note_input(logic op, logic side, pos_t pos);
      lsah_pkg::axis_result_t r;
      int           spd;
      bit           mode;
      bit           cal;
      bit           hit;
      spd  = int'(speed_mag);
      mode = 1'b0;
      cal  = 1'b0;
      hit  = 1'b0;
      if (!homed) begin
        if (op == lsah_pkg::OP_LIMIT) begin
          if (first_pending) begin
            speed         = pos_t'((side == lsah_pkg::SIDE_FWD) ? spd : -spd);
            first_pending = 1'b0;
            mode          = 1'b1;
          end else if (side == lsah_pkg::SIDE_FWD && !fwd_seen) begin
            fwd_seen = 1'b1;
            speed    = pos_t'(-spd);
            max_pos  = last_pos;
            mode     = 1'b1;
          end else if (side == lsah_pkg::SIDE_REAR && !rear_seen) begin
            rear_seen = 1'b1;
            speed     = pos_t'(spd);
            min_pos   = last_pos;
            mode      = 1'b1;
          end
          if (calibrated()) begin
            // Division truncates toward zero, matching the setpoint rule.
            mid_pos = pos_t'((int'(max_pos) + int'(min_pos)) / 2);
            speed   = pos_t'((int'(mid_pos) - int'(last_pos) >= 0) ? spd : -spd);
            cal     = 1'b1;
          end
        end else begin
          if (homes(pos)) begin
            mode  = 1'b1;
            hit   = 1'b1;
            speed = '0;
            homed = 1'b1;
          end
          last_pos = pos;
        end
      end
      r.speed_cmd   = speed;
      r.mode_pulse  = mode;
      r.calibrated  = cal;
      r.setpoint    = cal ? mid_pos : '0;
      r.range_min   = cal ? min_pos : '0;
      r.range_max   = cal ? max_pos : '0;
      r.homing_done = hit;
      pending.push_back(r);
    endfunction

    function void cmp(string name, pos_t want, pos_t got);
      if (want !== got) begin
        $error("%s: expected %0d, actual %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(lsah_pkg::axis_result_t got);
      lsah_pkg::axis_result_t want;
      if (pending.size() == 0) begin
        $error("result with no pending expectation: speed_cmd %0d", got.speed_cmd);
        errors++;
        return;
      end
      want = pending.pop_front();
      cmp("speed_cmd", want.speed_cmd, got.speed_cmd);
      cmp("mode_pulse", pos_t'(want.mode_pulse), pos_t'(got.mode_pulse));
      cmp("calibrated", pos_t'(want.calibrated), pos_t'(got.calibrated));
      cmp("setpoint", want.setpoint, got.setpoint);
      cmp("range_min", want.range_min, got.range_min);
      cmp("range_max", want.range_max, got.range_max);
      cmp("homing_done", pos_t'(want.homing_done), pos_t'(got.homing_done));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  int   in_idle_pct;
  int   out_stall_pct;
  int   quiet;

  lsah_in_if  in_bus();
  lsah_out_if out_bus();
  lsah_cfg_if cfg_bus();

  axis_homing_scoreboard sb = new();

  limit_switch_axis_homing_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_bus),
    .out_if (out_bus),
    .cfg_if (cfg_bus)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Take results, stalling at the rate of the current phase.
  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready) begin
      sb.check_result('{speed_cmd: out_bus.speed_cmd, mode_pulse: out_bus.mode_pulse,
                        calibrated: out_bus.calibrated, setpoint: out_bus.setpoint,
                        range_min: out_bus.range_min, range_max: out_bus.range_max,
                        homing_done: out_bus.homing_done});
    end
    out_bus.ready <= ($urandom_range(0, 99) >= out_stall_pct);
  end

  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet == WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Write both registers back to back; valid stays high between the two transactions.
  task automatic configure(speed_t spd, tol_t tl);
    cfg_word_t tol_word;
    tol_word                     = cfg_word_t'($urandom);
    tol_word[lsah_pkg::TOL_W-1:0] = tl;
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= lsah_pkg::CFG_DRIVE_SPEED;
    cfg_bus.data  <= cfg_word_t'(spd);
    do @(posedge clk); while (!cfg_bus.ready);
    sb.set_reg(lsah_pkg::CFG_DRIVE_SPEED, cfg_word_t'(spd));
    cfg_bus.index <= lsah_pkg::CFG_HOME_TOL;
    cfg_bus.data  <= tol_word;
    do @(posedge clk); while (!cfg_bus.ready);
    sb.set_reg(lsah_pkg::CFG_HOME_TOL, tol_word);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic send_item(logic op, logic side, pos_t pos);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid      <= 1'b1;
    in_bus.op         <= op;
    in_bus.limit_side <= side;
    in_bus.position   <= pos;
    do @(posedge clk); while (!in_bus.ready);
    sb.note_input(op, side, pos);
  endtask

  task automatic random_item(bit allow_home);
    logic                    op;
    logic                    side;
    pos_t                    pos;
    int                      near;
    int                      pick;
    op   = ($urandom_range(0, 99) < 70) ? lsah_pkg::OP_POSITION : lsah_pkg::OP_LIMIT;
    side = 1'($urandom_range(0, 1));
    pos  = pos_t'($urandom);
    if (op == lsah_pkg::OP_POSITION && sb.calibrated()) begin
      pick = $urandom_range(0, 99);
      near = 40000;
      if (allow_home && pick < 25) begin
        near = int'(sb.mid_pos) + int'($urandom_range(0, 600)) - 300;
      end else if (pick < 35) begin
        // Exactly on the edge of the window: must not end homing.
        near = int'(sb.mid_pos) +
               ((side == lsah_pkg::SIDE_REAR) ? int'(sb.tol) : -int'(sb.tol));
      end
      if (near >= -32768 && near <= 32767) pos = pos_t'(near);
      if (!allow_home) begin
        while (sb.homes(pos)) pos = pos_t'($urandom);
      end
    end
    send_item(op, side, pos);
  endtask

  task automatic wait_drained();
    in_bus.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  task automatic set_idling(int mode);
    case (mode)
      0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
      1: begin in_idle_pct = 63; out_stall_pct = 0;  end
      2: begin in_idle_pct = 0;  out_stall_pct = 63; end
      default: begin in_idle_pct = 15; out_stall_pct = 15; end
    endcase
  endtask

  task automatic run_directed();
    logic                    first_side;
    pos_t                    max_rec;
    pos_t                    min_rec;
    pos_t                    mid_exp;
    first_side = 1'($urandom_range(0, 1));
    max_rec    = pos_t'($urandom_range(0, 31000));
    // Odd negative sum of the limits exercises truncation toward zero.
    min_rec    = pos_t'(-(int'(max_rec) + 2 * int'($urandom_range(0, 800)) + 1));
    mid_exp    = pos_t'((int'(max_rec) + int'(min_rec)) / 2);
    send_item(lsah_pkg::OP_POSITION, lsah_pkg::SIDE_REAR, 16'sh7fff);
    send_item(lsah_pkg::OP_POSITION, lsah_pkg::SIDE_FWD, -16'sh8000);
    send_item(lsah_pkg::OP_LIMIT, first_side, 16'sh7fff);
    send_item(lsah_pkg::OP_POSITION, lsah_pkg::SIDE_FWD, min_rec);
    send_item(lsah_pkg::OP_LIMIT, lsah_pkg::SIDE_REAR, -16'sh8000);
    send_item(lsah_pkg::OP_LIMIT, lsah_pkg::SIDE_REAR, '0);
    send_item(lsah_pkg::OP_POSITION, lsah_pkg::SIDE_REAR, max_rec);
    send_item(lsah_pkg::OP_LIMIT, lsah_pkg::SIDE_FWD, '1);
    send_item(lsah_pkg::OP_LIMIT, lsah_pkg::SIDE_FWD, '0);
    // Zero tolerance: sitting on the midpoint keeps homing going.
    send_item(lsah_pkg::OP_POSITION, lsah_pkg::SIDE_FWD, mid_exp);
    send_item(lsah_pkg::OP_LIMIT, lsah_pkg::SIDE_REAR, '1);
    send_item(lsah_pkg::OP_POSITION, lsah_pkg::SIDE_REAR, -16'sh8000);
    send_item(lsah_pkg::OP_LIMIT, lsah_pkg::SIDE_FWD, 16'sh7fff);
    send_item(lsah_pkg::OP_POSITION, lsah_pkg::SIDE_FWD, 16'sh7fff);
    send_item(lsah_pkg::OP_LIMIT, lsah_pkg::SIDE_REAR, -16'sh8000);
  endtask

  initial begin
    speed_t spd;
    tol_t   tl;
    rst_n             <= 1'b0;
    in_bus.valid      <= 1'b0;
    in_bus.op         <= lsah_pkg::OP_LIMIT;
    in_bus.limit_side <= lsah_pkg::SIDE_FWD;
    in_bus.position   <= '0;
    cfg_bus.valid     <= 1'b0;
    cfg_bus.index     <= lsah_pkg::CFG_DRIVE_SPEED;
    cfg_bus.data      <= '0;
    set_idling(0);
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    configure('1, '0);
    run_directed();

    for (int p = 0; p < 6; p++) begin
      wait_drained();
      spd = speed_t'($urandom);
      tl  = tol_t'($urandom);
      case (p)
        0: configure('0, '1);
        2: configure('1, 8'd1);
        5: configure(spd, '0);
        default: configure(spd, tl);
      endcase
      set_idling(p % 4);
      repeat (PHASE_ITEMS) random_item(1'b0);
    end

    // Home the axis, then feed inputs that must be ignored.
    wait_drained();
    spd = speed_t'($urandom);
    configure(spd, '1);
    set_idling(3);
    for (int i = 0; i < HOMING_ITEMS && !sb.homed; i++) random_item(1'b1);
    repeat (IGNORED_ITEMS) random_item(1'b1);

    wait_drained();
    repeat (5) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: limit_switch_axis_homing_top.f
rtl/core/lsah_pkg.sv
rtl/core/lsah_in_if.sv
rtl/core/lsah_out_if.sv
rtl/core/lsah_cfg_if.sv
rtl/core/lsah_step.sv
rtl/core/limit_switch_axis_homing_top.sv
rtl/core/lsah_checker.sv
tb/tb_limit_switch_axis_homing_top.sv
